// ===== design/fbc_pkg.sv =====
`default_nettype none
package fbc_pkg;

	localparam int PLANE_W   = 64;
	localparam int NORM_W    = 16;
	localparam int Q_FRAC    = 14;
	localparam int RADIUS_W  = 15;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] CMD_POINT  = 2'd0;
	localparam logic [1:0] CMD_BOX    = 2'd1;
	localparam logic [1:0] CMD_SPHERE = 2'd2;

	localparam logic [1:0] OV_OUT  = 2'd0;
	localparam logic [1:0] OV_PART = 2'd1;
	localparam logic [1:0] OV_FULL = 2'd2;

	// load enables of the stages inside a plane lane
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage
`default_nettype wire

// ===== design/frustum_bound_culling.sv =====
// frustum_bound_culling: classifies points, axis-aligned boxes and spheres
// against PLANE_COUNT frustum planes and answers outside, partial or inside.
// planes are loaded through the cfg channel (cfg_index selects the plane,
// cfg_data packs a,b,c in Q1.14 and d in bits 63:48); cfg_ready is always
// high and writes to an index past the last plane are dropped. load planes
// only while no word is in flight.
// the input channel (in_valid/in_ready) takes one volume word per cycle
// while in_ready is high; the output channel (out_valid/out_ready) returns
// one overlap word per input in order. an accepted word is taken into the
// input register, then passes corner select and multiply, plane sum and
// compare, and the reduction into the output register that drives out_valid.
// sustained throughput is one word per clock while out_ready stays high,
// set by the per-plane multiplier lanes, which all run in parallel.
// when out_ready is low the stages stall from the output backwards; empty
// stages keep filling, so up to four words are held before in_ready drops,
// and nothing is lost or repeated. reset clears all valid bits and zeroes
// every plane register.
`default_nettype none
module frustum_bound_culling
	import fbc_pkg::*;
#(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [PLANE_W-1:0]           cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   cmd,
	input  wire logic signed [COORD_BITS-1:0] point_x,
	input  wire logic signed [COORD_BITS-1:0] point_y,
	input  wire logic signed [COORD_BITS-1:0] point_z,
	input  wire logic signed [COORD_BITS-1:0] far_x,
	input  wire logic signed [COORD_BITS-1:0] far_y,
	input  wire logic signed [COORD_BITS-1:0] far_z,
	input  wire logic [RADIUS_W-1:0]          radius,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        overlap
);

	logic [PLANE_W-1:0] planes_q [PLANE_COUNT];

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s4;
	stage_en_t en;

	logic [1:0]                   cmd_s1, cmd_s2, cmd_s3;
	logic signed [COORD_BITS-1:0] lo_x_s1, lo_y_s1, lo_z_s1;
	logic signed [COORD_BITS-1:0] hi_x_s1, hi_y_s1, hi_z_s1;
	logic [RADIUS_W-1:0]          radius_s1, radius_s2;
	logic [PLANE_COUNT-1:0]       outside_s3, partial_s3;

	assign cfg_ready = 1'b1;

	fbc_cfg_regs #(
		.PLANE_COUNT(PLANE_COUNT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.planes_q (planes_q)
	);

	// a stage loads when it is empty or its word moves on
	assign en_s4    = !out_valid || out_ready;
	assign en.s3    = !v_s3 || en_s4;
	assign en.s2    = !v_s2 || en.s3;
	assign en_s1    = !v_s1 || en.s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en_s4) out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1    <= cmd;
			lo_x_s1   <= point_x;
			lo_y_s1   <= point_y;
			lo_z_s1   <= point_z;
			hi_x_s1   <= far_x;
			hi_y_s1   <= far_y;
			hi_z_s1   <= far_z;
			radius_s1 <= radius;
		end
		if (en.s2) begin
			cmd_s2    <= cmd_s1;
			radius_s2 <= radius_s1;
		end
		if (en.s3) begin
			cmd_s3 <= cmd_s2;
		end
	end

	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
		fbc_plane_lane #(
			.COORD_BITS(COORD_BITS)
		) u_lane (
			.clk       (clk),
			.en        (en),
			.plane     (planes_q[g]),
			.cmd_s1    (cmd_s1),
			.lo_x_s1   (lo_x_s1),
			.lo_y_s1   (lo_y_s1),
			.lo_z_s1   (lo_z_s1),
			.hi_x_s1   (hi_x_s1),
			.hi_y_s1   (hi_y_s1),
			.hi_z_s1   (hi_z_s1),
			.cmd_s2    (cmd_s2),
			.radius_s2 (radius_s2),
			.outside_s3(outside_s3[g]),
			.partial_s3(partial_s3[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			// unused command code reads as outside
			if ((cmd_s3 != CMD_POINT && cmd_s3 != CMD_BOX && cmd_s3 != CMD_SPHERE)
					|| (|outside_s3)) begin
				overlap <= OV_OUT;
			end else if (|partial_s3) begin
				overlap <= OV_PART;
			end else begin
				overlap <= OV_FULL;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/fbc_cfg_regs.sv =====
`default_nettype none
module fbc_cfg_regs
	import fbc_pkg::*;
#(
	parameter int PLANE_COUNT = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PLANE_W-1:0]   cfg_data,
	output logic      [PLANE_W-1:0]   planes_q [PLANE_COUNT]
);

	// writes past the last plane fall through every compare and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				planes_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					planes_q[i] <= cfg_data;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/fbc_plane_lane.sv =====
`default_nettype none
module fbc_plane_lane
	import fbc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire stage_en_t                    en,
	input  wire logic [PLANE_W-1:0]           plane,
	input  wire logic [1:0]                   cmd_s1,
	input  wire logic signed [COORD_BITS-1:0] lo_x_s1,
	input  wire logic signed [COORD_BITS-1:0] lo_y_s1,
	input  wire logic signed [COORD_BITS-1:0] lo_z_s1,
	input  wire logic signed [COORD_BITS-1:0] hi_x_s1,
	input  wire logic signed [COORD_BITS-1:0] hi_y_s1,
	input  wire logic signed [COORD_BITS-1:0] hi_z_s1,
	input  wire logic [1:0]                   cmd_s2,
	input  wire logic [RADIUS_W-1:0]          radius_s2,
	output logic                              outside_s3,
	output logic                              partial_s3
);

	localparam int PW = NORM_W + COORD_BITS;
	localparam int SW = ((PW > NORM_W + Q_FRAC) ? PW : NORM_W + Q_FRAC) + 2;

	logic signed [NORM_W-1:0] na, nb, nc, nd;
	logic signed [PW-1:0]     na_e, nb_e, nc_e;
	logic signed [PW-1:0]     px_e, py_e, pz_e, qx_e, qy_e, qz_e;
	logic signed [PW-1:0]     ppx_s2, ppy_s2, ppz_s2, npx_s2, npy_s2, npz_s2;
	logic signed [SW-1:0]     d_sc, r_sc, pdist, ndist;
	logic                     box;

	assign na = plane[15:0];
	assign nb = plane[31:16];
	assign nc = plane[47:32];
	assign nd = plane[63:48];
	assign na_e = PW'(na);
	assign nb_e = PW'(nb);
	assign nc_e = PW'(nc);
	assign box = (cmd_s1 == CMD_BOX);

	// positive vertex goes in p*, negative vertex in q*; other volumes use the low corner
	always_comb begin
		px_e = PW'((box && !na[NORM_W-1]) ? hi_x_s1 : lo_x_s1);
		py_e = PW'((box && !nb[NORM_W-1]) ? hi_y_s1 : lo_y_s1);
		pz_e = PW'((box && !nc[NORM_W-1]) ? hi_z_s1 : lo_z_s1);
		qx_e = PW'((box && na[NORM_W-1]) ? hi_x_s1 : lo_x_s1);
		qy_e = PW'((box && nb[NORM_W-1]) ? hi_y_s1 : lo_y_s1);
		qz_e = PW'((box && nc[NORM_W-1]) ? hi_z_s1 : lo_z_s1);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ppx_s2 <= na_e * px_e;
			ppy_s2 <= nb_e * py_e;
			ppz_s2 <= nc_e * pz_e;
			npx_s2 <= na_e * qx_e;
			npy_s2 <= nb_e * qy_e;
			npz_s2 <= nc_e * qz_e;
		end
	end

	// distances in units of 2^-14
	always_comb begin
		d_sc  = SW'(nd) <<< Q_FRAC;
		r_sc  = signed'({(SW - RADIUS_W - Q_FRAC)'(0), radius_s2, Q_FRAC'(0)});
		pdist = SW'(ppx_s2) + SW'(ppy_s2) + SW'(ppz_s2) + d_sc;
		ndist = SW'(npx_s2) + SW'(npy_s2) + SW'(npz_s2) + d_sc;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (cmd_s2 == CMD_SPHERE) begin
				outside_s3 <= (pdist <= -r_sc);
				partial_s3 <= (pdist < r_sc);
			end else begin
				outside_s3 <= pdist[SW-1];
				partial_s3 <= (cmd_s2 == CMD_BOX) && ndist[SW-1];
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/frustum_bound_culling_tb.sv =====
`timescale 1ns / 1ps
module frustum_bound_culling_tb;
	import fbc_pkg::*;

	localparam int NUM_PLANES  = 6;
	localparam int COORD_W     = 16;
	localparam int COORD_MAX   = 32767;
	localparam int COORD_MIN   = -32768;
	localparam int Q_UNIT      = 16384;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP   = 200;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_WORDS = 150;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int REG_LEFT     = 0;
	localparam int REG_RIGHT    = 1;
	localparam int REG_BOTTOM   = 2;
	localparam int REG_TOP      = 3;
	localparam int REG_NEAR     = 4;
	localparam int REG_FAR      = 5;
	localparam int REG_SPARE_LO = 6;
	localparam int REG_SPARE_HI = 7;

	typedef struct {
		logic [1:0]          op;
		logic signed [15:0]  lx, ly, lz;
		logic signed [15:0]  hx, hy, hz;
		logic [RADIUS_W-1:0] rad;
	} volume_t;

	class culling_scoreboard;
		logic [PLANE_W-1:0] planes [NUM_PLANES];
		logic [1:0]         overlap_q [$];
		int                 errors;

		function new();
			foreach (planes[i]) planes[i] = '0;
			errors = 0;
		endfunction

		function void load_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] val);
			if (idx < NUM_PLANES)
				planes[idx] = val;
		endfunction

		// distance scaled by 2^14, exact
		function longint plane_distance(logic [PLANE_W-1:0] p, longint x, longint y, longint z);
			return longint'($signed(p[15:0])) * x + longint'($signed(p[31:16])) * y
			     + longint'($signed(p[47:32])) * z + (longint'($signed(p[63:48])) <<< Q_FRAC);
		endfunction

		function logic [1:0] classify(volume_t v);
			longint ctr_d, pos_d, neg_d, rq;
			bit     outside, partial;
			logic [PLANE_W-1:0] p;
			outside = 1'b0;
			partial = 1'b0;
			rq = longint'(v.rad) <<< Q_FRAC;
			if (v.op == CMD_UNUSED)
				return OV_OUT;
			for (int i = 0; i < NUM_PLANES; i++) begin
				p = planes[i];
				case (v.op)
					CMD_POINT: begin
						if (plane_distance(p, v.lx, v.ly, v.lz) < 0)
							outside = 1'b1;
					end
					CMD_BOX: begin
						// normal sign bits pick the corner farthest along the normal, and the nearest for neg_d
						pos_d = plane_distance(p, p[15] ? v.lx : v.hx, p[31] ? v.ly : v.hy,
						                       p[47] ? v.lz : v.hz);
						neg_d = plane_distance(p, p[15] ? v.hx : v.lx, p[31] ? v.hy : v.ly,
						                       p[47] ? v.hz : v.lz);
						if (pos_d < 0)
							outside = 1'b1;
						if (neg_d < 0)
							partial = 1'b1;
					end
					default: begin
						ctr_d = plane_distance(p, v.lx, v.ly, v.lz);
						if (ctr_d <= -rq)
							outside = 1'b1;
						if (ctr_d < rq)
							partial = 1'b1;
					end
				endcase
			end
			return outside ? OV_OUT : (partial ? OV_PART : OV_FULL);
		endfunction

		function void note_volume(volume_t v);
			overlap_q.push_back(classify(v));
		endfunction

		function void check_overlap(logic [1:0] got);
			logic [1:0] want;
			if (overlap_q.size() == 0) begin
				if (errors < PRINT_CAP)
					$display("%0t: overlap word with nothing pending, expected none, got %0d",
					         $time, got);
				errors++;
				return;
			end
			want = overlap_q.pop_front();
			if (got !== want) begin
				if (errors < PRINT_CAP)
					$display("%0t: overlap mismatch, expected %0d, got %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [PLANE_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                cmd;
	logic signed [COORD_W-1:0] point_x, point_y, point_z;
	logic signed [COORD_W-1:0] far_x, far_y, far_z;
	logic [RADIUS_W-1:0]       radius;
	logic                      out_valid;
	logic                      out_ready;
	logic [1:0]                overlap;

	culling_scoreboard board;
	volume_t           seen;
	bit                steady = 1'b0;
	int                cycle_count = 0;

	frustum_bound_culling #(
		.PLANE_COUNT(NUM_PLANES),
		.COORD_BITS (COORD_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.far_x     (far_x),
		.far_y     (far_y),
		.far_z     (far_z),
		.radius    (radius),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.overlap   (overlap)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("frustum_bound_culling_tb NOT OK");
			$finish;
		end
	end

	// everything that crosses the ports is seen here, in edge order
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.load_plane(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				seen = '{cmd, point_x, point_y, point_z, far_x, far_y, far_z, radius};
				board.note_volume(seen);
			end
			if (out_valid && out_ready)
				board.check_overlap(overlap);
		end
	end

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 33);

	function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
		return {16'(d), 16'(c), 16'(b), 16'(a)};
	endfunction

	function automatic int clip16(int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	function automatic int wide_coord(int span);
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(0, 65535)) + COORD_MIN;
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// all driving tasks start and end at a falling edge
	task automatic write_plane(input int idx, input logic [PLANE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_volume(input logic [1:0] op, input int lx, ly, lz, hx, hy, hz,
	                           input int rad);
		if (!steady) begin
			while ($urandom_range(0, 99) < 33) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		cmd      <= op;
		point_x  <= 16'(lx);
		point_y  <= 16'(ly);
		point_z  <= 16'(lz);
		far_x    <= 16'(hx);
		far_y    <= 16'(hy);
		far_z    <= 16'(hz);
		radius   <= RADIUS_W'(rad);
		do @(posedge clk); while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.overlap_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic load_random_planes(input bit shaped);
		int nrm [3];
		int off;
		int lean;
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (shaped) begin
				// roughly a box-shaped frustum with tilted normals
				lean = (i % 2 == 0) ? 1 : -1;
				for (int k = 0; k < 3; k++)
					nrm[k] = int'($urandom_range(0, 6000)) - 3000;
				nrm[i / 2] = lean * (Q_UNIT - int'($urandom_range(0, 2000)));
				off = int'($urandom_range(0, 22000)) - 2000;
				write_plane(i, pack_plane(nrm[0], nrm[1], nrm[2], off));
			end else begin
				write_plane(i, {$urandom, $urandom});
			end
		end
		write_plane($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_volume();
		int pick, rad;
		int c [3];
		int e [3];
		int lo [3];
		int hi [3];
		logic [1:0] op;
		pick = $urandom_range(0, 99);
		op = (pick < 30) ? CMD_POINT : (pick < 65) ? CMD_BOX :
		     (pick < 96) ? CMD_SPHERE : CMD_UNUSED;
		for (int k = 0; k < 3; k++) begin
			c[k] = wide_coord(22000);
			e[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40000) : $urandom_range(0, 3000);
			if (op == CMD_BOX) begin
				lo[k] = clip16(c[k] - e[k]);
				hi[k] = clip16(c[k] + e[k]);
			end else begin
				lo[k] = c[k];
				hi[k] = int'($urandom_range(0, 65535)) + COORD_MIN;
			end
		end
		rad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 3000);
		// inverted box now and then
		if (op == CMD_BOX && $urandom_range(0, 9) == 0)
			send_volume(op, hi[0], hi[1], hi[2], lo[0], lo[1], lo[2], rad);
		else
			send_volume(op, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], rad);
	endtask

	initial begin
		board     = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		cmd       = CMD_POINT;
		point_x   = '0;
		point_y   = '0;
		point_z   = '0;
		far_x     = '0;
		far_y     = '0;
		far_z     = '0;
		radius    = '0;
		out_ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// planes still at reset: every distance is zero
		send_volume(CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_SPHERE, 0, 0, 0, 0, 0, 0, COORD_MAX);
		send_volume(CMD_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		send_volume(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0);
		drain();

		// axis-aligned cube of half width 1000
		write_plane(REG_LEFT,   pack_plane(Q_UNIT, 0, 0, 1000));
		write_plane(REG_RIGHT,  pack_plane(-Q_UNIT, 0, 0, 1000));
		write_plane(REG_BOTTOM, pack_plane(0, Q_UNIT, 0, 1000));
		write_plane(REG_TOP,    pack_plane(0, -Q_UNIT, 0, 1000));
		write_plane(REG_NEAR,   pack_plane(0, 0, Q_UNIT, 1000));
		write_plane(REG_FAR,    pack_plane(0, 0, -Q_UNIT, 1000));
		cfg_valid <= 1'b0;
		send_volume(CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_POINT, 1000, -1000, 1000, 0, 0, 0, 0);
		send_volume(CMD_POINT, 1001, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
		            COORD_MAX);
		send_volume(CMD_BOX, -10, -10, -10, 10, 10, 10, 0);
		send_volume(CMD_BOX, -2000, -10, -10, 0, 10, 10, 0);
		send_volume(CMD_BOX, 1001, 0, 0, 2000, 10, 10, 0);
		send_volume(CMD_BOX, 500, 500, 500, -500, -500, -500, 0);
		send_volume(CMD_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		send_volume(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0);
		// sphere touching a plane from outside, then just reaching inside
		send_volume(CMD_SPHERE, 1000, 0, 0, 0, 0, 0, 0);
		send_volume(CMD_SPHERE, 1005, 0, 0, 0, 0, 0, 5);
		send_volume(CMD_SPHERE, 1004, 0, 0, 0, 0, 0, 5);
		send_volume(CMD_SPHERE, 0, 0, 0, 0, 0, 0, COORD_MAX);
		send_volume(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0);
		drain();

		// extreme normals and offsets, plus writes past the last plane
		write_plane(REG_LEFT,   pack_plane(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
		write_plane(REG_RIGHT,  pack_plane(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
		write_plane(REG_BOTTOM, pack_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		write_plane(REG_TOP,    pack_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		write_plane(REG_NEAR,   pack_plane(1, -1, 1, 0));
		write_plane(REG_FAR,    pack_plane(-1, 1, -1, COORD_MAX));
		write_plane(REG_SPARE_LO, '1);
		write_plane(REG_SPARE_HI, '1);
		cfg_valid <= 1'b0;
		send_volume(CMD_POINT, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0, 0);
		send_volume(CMD_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		send_volume(CMD_SPHERE, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, COORD_MAX);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			load_random_planes(ph % 4 != 3);
			steady = (ph == 5);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_random_volume();
			drain();
			steady = 1'b0;
		end

		repeat (16) @(negedge clk);
		if (board.errors == 0 && board.overlap_q.size() == 0)
			$display("frustum_bound_culling_tb OK");
		else
			$display("frustum_bound_culling_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
design/fbc_pkg.sv
design/fbc_cfg_regs.sv
design/fbc_plane_lane.sv
design/frustum_bound_culling.sv
tb/sv/frustum_bound_culling_tb.sv
